@@ rtl/ulpp_pkg.sv @@
// shared constants for the serial link ping-pong tester
`default_nettype none

package ulpp_pkg;

    // control bytes of the link protocol
    localparam logic [7:0] CTL_HELLO = 8'h80;
    localparam logic [7:0] CTL_ACK   = 8'h81;
    localparam logic [7:0] CTL_START = 8'h82;
    localparam logic [7:0] CTL_END   = 8'h83;

    // ping-pong value sequence runs 0..VALUE_TOP and wraps
    localparam int unsigned VALUE_WIDTH = 7;
    localparam logic [VALUE_WIDTH-1:0] VALUE_TOP = 7'd99;

    // widths of the register and report fields
    localparam int unsigned BATCH_LEN_WIDTH   = 14;
    localparam int unsigned REPORT_WIDTH      = 14;
    localparam logic [BATCH_LEN_WIDTH-1:0] BATCH_LEN_RESET = 14'd10;

    // default counter width
    localparam int unsigned COUNT_WIDTH_DEFAULT = 14;

endpackage

`default_nettype wire

@@ rtl/uart_link_ping_pong_tester.sv @@
// top level of the serial link ping-pong tester
`default_nettype none

// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  s_rx_byte
// m_        out        m_valid / m_ready  m_tx_valid, m_tx_byte, m_batch_done,
//                                         m_report_received, m_report_sent,
//                                         m_report_bad, m_link_ready
// cfg_      in         cfg_wr_en          cfg_wr_data (batch length)
//
// one transfer in and one transfer out per clock when both sides keep up;
// an item passes the input register, then the result register
// the update logic (byte decode, saturating increments and compares) sits between them
// reset (aresetn low, synchronous) empties both stages, clears the counters,
// the ready flag and the last value, and sets batch length to 10
// a stall on m_ready holds the result; the input stage still takes one more
// transfer and then drops s_ready
module uart_link_ping_pong_tester
    import ulpp_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = ulpp_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // configuration write
    input  wire logic                                   cfg_wr_en,
    input  wire logic [ulpp_pkg::BATCH_LEN_WIDTH-1:0]   cfg_wr_data,
    // received bytes
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic [7:0]                             s_rx_byte,
    // results
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic                                        m_tx_valid,
    output logic [7:0]                                  m_tx_byte,
    output logic                                        m_batch_done,
    output logic [ulpp_pkg::REPORT_WIDTH-1:0]           m_report_received,
    output logic [ulpp_pkg::REPORT_WIDTH-1:0]           m_report_sent,
    output logic [ulpp_pkg::REPORT_WIDTH-1:0]           m_report_bad,
    output logic                                        m_link_ready
);

    // compare and report width covers both counter and field widths
    localparam int unsigned CMP_W =
        (COUNT_WIDTH > BATCH_LEN_WIDTH) ? COUNT_WIDTH : BATCH_LEN_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    // configuration register
    logic [BATCH_LEN_WIDTH-1:0] batch_len_reg;

    // input stage
    logic       in_valid_reg;
    logic [7:0] rx_byte_reg;

    // link state
    logic                   ready_flag_reg,  ready_flag_next;
    logic [VALUE_WIDTH-1:0] last_value_reg,  last_value_next;
    logic [COUNT_WIDTH-1:0] rcv_count_reg,   rcv_count_next;
    logic [COUNT_WIDTH-1:0] sent_count_reg,  sent_count_next;
    logic [COUNT_WIDTH-1:0] err_count_reg,   err_count_next;

    // result stage
    logic                    out_valid_reg;
    logic                    tx_valid_reg,   tx_valid_next;
    logic [7:0]              tx_byte_reg,    tx_byte_next;
    logic                    done_reg,       done_next;
    logic [REPORT_WIDTH-1:0] rpt_rcv_reg,    rpt_rcv_next;
    logic [REPORT_WIDTH-1:0] rpt_sent_reg,   rpt_sent_next;
    logic [REPORT_WIDTH-1:0] rpt_bad_reg,    rpt_bad_next;
    logic                    link_ready_reg;

    // datapath helpers
    logic                   advance;
    logic [COUNT_WIDTH-1:0] rcv_inc, sent_inc, bad_inc;
    logic [CMP_W-1:0]       rcv_inc_ext, rcv_ext, sent_ext, bad_ext, batch_ext;
    logic [VALUE_WIDTH-1:0] expect_value, after_expect;

    // stage handshake
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // saturating increments and widened copies
    always_comb begin
        rcv_inc     = (rcv_count_reg  == CNT_MAX) ? rcv_count_reg  : rcv_count_reg  + 1'b1;
        sent_inc    = (sent_count_reg == CNT_MAX) ? sent_count_reg : sent_count_reg + 1'b1;
        bad_inc     = (err_count_reg  == CNT_MAX) ? err_count_reg  : err_count_reg  + 1'b1;
        rcv_inc_ext = CMP_W'(rcv_inc);
        rcv_ext     = CMP_W'(rcv_count_reg);
        sent_ext    = CMP_W'(sent_count_reg);
        bad_ext     = CMP_W'(err_count_reg);
        batch_ext   = CMP_W'(batch_len_reg);
    end

    // expected value and the one after it, both wrapping past the top
    always_comb begin
        expect_value = (last_value_reg >= VALUE_TOP) ? '0 : last_value_reg + 1'b1;
        after_expect = (expect_value   >= VALUE_TOP) ? '0 : expect_value   + 1'b1;
    end

    // byte decode and state update
    always_comb begin
        ready_flag_next = ready_flag_reg;
        last_value_next = last_value_reg;
        rcv_count_next  = rcv_count_reg;
        sent_count_next = sent_count_reg;
        err_count_next  = err_count_reg;
        tx_valid_next   = 1'b0;
        tx_byte_next    = '0;
        done_next       = 1'b0;
        rpt_rcv_next    = '0;
        rpt_sent_next   = '0;
        rpt_bad_next    = '0;
        case (rx_byte_reg)
            CTL_HELLO: begin
                ready_flag_next = 1'b1;
                tx_valid_next   = 1'b1;
                tx_byte_next    = CTL_ACK;
            end
            CTL_ACK: begin
                ready_flag_next = 1'b1;
            end
            CTL_START: begin
                last_value_next = VALUE_WIDTH'(1);
                tx_valid_next   = 1'b1;
                tx_byte_next    = 8'd1;
                sent_count_next = sent_inc;
            end
            CTL_END: begin
                done_next       = 1'b1;
                rpt_rcv_next    = rcv_ext[REPORT_WIDTH-1:0];
                rpt_sent_next   = sent_ext[REPORT_WIDTH-1:0];
                rpt_bad_next    = bad_ext[REPORT_WIDTH-1:0];
                rcv_count_next  = '0;
                sent_count_next = '0;
                err_count_next  = '0;
                last_value_next = '0;
            end
            default: begin
                if (rcv_inc_ext == batch_ext) begin
                    // batch complete: report including this byte
                    tx_valid_next   = 1'b1;
                    tx_byte_next    = CTL_END;
                    done_next       = 1'b1;
                    rpt_rcv_next    = rcv_inc_ext[REPORT_WIDTH-1:0];
                    rpt_sent_next   = sent_ext[REPORT_WIDTH-1:0];
                    rpt_bad_next    = bad_ext[REPORT_WIDTH-1:0];
                    rcv_count_next  = '0;
                    sent_count_next = '0;
                    err_count_next  = '0;
                    last_value_next = '0;
                end else begin
                    rcv_count_next = rcv_inc;
                    if ({1'b0, expect_value} != rx_byte_reg) begin
                        err_count_next = bad_inc;
                    end
                    last_value_next = after_expect;
                    tx_valid_next   = 1'b1;
                    tx_byte_next    = {1'b0, after_expect};
                    sent_count_next = sent_inc;
                end
            end
        endcase
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            batch_len_reg <= BATCH_LEN_RESET;
        end else if (cfg_wr_en) begin
            batch_len_reg <= cfg_wr_data;
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            rx_byte_reg <= s_rx_byte;
        end
    end

    // link state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_flag_reg <= 1'b0;
            last_value_reg <= '0;
            rcv_count_reg  <= '0;
            sent_count_reg <= '0;
            err_count_reg  <= '0;
        end else if (advance) begin
            ready_flag_reg <= ready_flag_next;
            last_value_reg <= last_value_next;
            rcv_count_reg  <= rcv_count_next;
            sent_count_reg <= sent_count_next;
            err_count_reg  <= err_count_next;
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            tx_valid_reg <= tx_valid_next;
            tx_byte_reg  <= tx_byte_next;
            done_reg     <= done_next;
            rpt_rcv_reg  <= rpt_rcv_next;
            rpt_sent_reg <= rpt_sent_next;
            rpt_bad_reg  <= rpt_bad_next;
        end
    end

    // link_ready of the result is the flag after its byte
    always_ff @(posedge aclk) begin
        if (advance) begin
            link_ready_reg <= ready_flag_next;
        end
    end

    // outputs
    assign m_valid           = out_valid_reg;
    assign m_tx_valid        = tx_valid_reg;
    assign m_tx_byte         = tx_byte_reg;
    assign m_batch_done      = done_reg;
    assign m_report_received = rpt_rcv_reg;
    assign m_report_sent     = rpt_sent_reg;
    assign m_report_bad      = rpt_bad_reg;
    assign m_link_ready      = link_ready_reg;

endmodule

`default_nettype wire

@@ tb/tb_uart_link_ping_pong_tester.sv @@
// self-checking testbench for the serial link ping-pong tester
`timescale 1ns / 1ps

import ulpp_pkg::*;

// one result transfer as seen on the m_ channel
typedef struct packed {
    logic                    tx_valid;
    logic [7:0]              tx_byte;
    logic                    batch_done;
    logic [REPORT_WIDTH-1:0] rpt_received;
    logic [REPORT_WIDTH-1:0] rpt_sent;
    logic [REPORT_WIDTH-1:0] rpt_bad;
    logic                    link_ready;
} link_result_t;

// ping-pong predictor plus the queue of answers still owed by the block
class link_scoreboard;
    logic                           link_up;
    logic [VALUE_WIDTH-1:0]         last_sent;
    logic [COUNT_WIDTH_DEFAULT-1:0] rx_count;
    logic [COUNT_WIDTH_DEFAULT-1:0] tx_count;
    logic [COUNT_WIDTH_DEFAULT-1:0] err_tally;
    logic [BATCH_LEN_WIDTH-1:0]     batch_len;
    link_result_t                   owed_answers[$];
    int                             mismatches;
    int                             bytes_in;
    int                             answers_checked;
    int                             batches_seen;

    function new();
        link_up         = 1'b0;
        last_sent       = '0;
        rx_count        = '0;
        tx_count        = '0;
        err_tally       = '0;
        batch_len       = BATCH_LEN_RESET;
        mismatches      = 0;
        bytes_in        = 0;
        answers_checked = 0;
        batches_seen    = 0;
    endfunction

    function void set_batch_len(logic [BATCH_LEN_WIDTH-1:0] v);
        batch_len = v;
    endfunction

    // sequence runs 0..VALUE_TOP and wraps
    function logic [VALUE_WIDTH-1:0] step_value(logic [VALUE_WIDTH-1:0] v);
        return (v >= VALUE_TOP) ? '0 : v + 1'b1;
    endfunction

    function logic [COUNT_WIDTH_DEFAULT-1:0] sat_inc(logic [COUNT_WIDTH_DEFAULT-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // data byte the peer should echo next
    function logic [7:0] next_expected();
        return {1'b0, step_value(last_sent)};
    endfunction

    // report the counters, then clear them and the sequence
    function void close_batch(inout link_result_t r);
        r.batch_done   = 1'b1;
        r.rpt_received = rx_count;
        r.rpt_sent     = tx_count;
        r.rpt_bad      = err_tally;
        rx_count       = '0;
        tx_count       = '0;
        err_tally      = '0;
        last_sent      = '0;
    endfunction

    // accepted input transfer: advance the prediction and owe one answer
    function void note_byte(logic [7:0] b);
        link_result_t           r;
        logic [VALUE_WIDTH-1:0] want;
        r = '0;
        bytes_in++;
        case (b)
            CTL_HELLO: begin
                link_up    = 1'b1;
                r.tx_valid = 1'b1;
                r.tx_byte  = CTL_ACK;
            end
            CTL_ACK: begin
                link_up = 1'b1;
            end
            CTL_START: begin
                last_sent  = VALUE_WIDTH'(1);
                r.tx_valid = 1'b1;
                r.tx_byte  = 8'd1;
                tx_count   = sat_inc(tx_count);
            end
            CTL_END: begin
                close_batch(r);
            end
            default: begin
                rx_count = sat_inc(rx_count);
                if (rx_count == batch_len) begin
                    r.tx_valid = 1'b1;
                    r.tx_byte  = CTL_END;
                    close_batch(r);
                end else begin
                    want = step_value(last_sent);
                    // bytes above the control range can never match
                    if ({1'b0, want} != b)
                        err_tally = sat_inc(err_tally);
                    last_sent  = step_value(want);
                    r.tx_valid = 1'b1;
                    r.tx_byte  = {1'b0, last_sent};
                    tx_count   = sat_inc(tx_count);
                end
            end
        endcase
        r.link_ready = link_up;
        owed_answers.push_back(r);
    endfunction

    task report_mismatch(string what, int got, int want);
        $display("[%0t] error: %s got %0d expected %0d (answer %0d)",
                 $time, what, got, want, answers_checked);
        mismatches++;
    endtask

    // accepted result transfer: compare with the oldest owed answer
    task check_result(link_result_t got);
        link_result_t want;
        if (owed_answers.size() == 0) begin
            report_mismatch("result with nothing owed, tx_byte", int'(got.tx_byte), 0);
        end else begin
            want = owed_answers.pop_front();
            if (want.batch_done)
                batches_seen++;
            if (got.tx_valid !== want.tx_valid)
                report_mismatch("tx_valid", int'(got.tx_valid), int'(want.tx_valid));
            if (got.tx_byte !== want.tx_byte)
                report_mismatch("tx_byte", int'(got.tx_byte), int'(want.tx_byte));
            if (got.batch_done !== want.batch_done)
                report_mismatch("batch_done", int'(got.batch_done),
                                int'(want.batch_done));
            if (got.rpt_received !== want.rpt_received)
                report_mismatch("report_received", int'(got.rpt_received),
                                int'(want.rpt_received));
            if (got.rpt_sent !== want.rpt_sent)
                report_mismatch("report_sent", int'(got.rpt_sent), int'(want.rpt_sent));
            if (got.rpt_bad !== want.rpt_bad)
                report_mismatch("report_bad", int'(got.rpt_bad), int'(want.rpt_bad));
            if (got.link_ready !== want.link_ready)
                report_mismatch("link_ready", int'(got.link_ready),
                                int'(want.link_ready));
        end
        answers_checked++;
    endtask
endclass

module tb_uart_link_ping_pong_tester;

    logic                       aclk        = 1'b0;
    logic                       aresetn     = 1'b0;
    logic                       cfg_wr_en   = 1'b0;
    logic [BATCH_LEN_WIDTH-1:0] cfg_wr_data = '0;
    logic                       s_valid     = 1'b0;
    logic [7:0]                 s_rx_byte   = '0;
    logic                       m_ready     = 1'b0;
    logic                       s_ready;
    logic                       m_valid;
    logic                       m_tx_valid;
    logic [7:0]                 m_tx_byte;
    logic                       m_batch_done;
    logic [REPORT_WIDTH-1:0]    m_report_received;
    logic [REPORT_WIDTH-1:0]    m_report_sent;
    logic [REPORT_WIDTH-1:0]    m_report_bad;
    logic                       m_link_ready;

    link_scoreboard sb = new();
    int             idle_max = 5;

    uart_link_ping_pong_tester u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_tx_valid        (m_tx_valid),
        .m_tx_byte         (m_tx_byte),
        .m_batch_done      (m_batch_done),
        .m_report_received (m_report_received),
        .m_report_sent     (m_report_sent),
        .m_report_bad      (m_report_bad),
        .m_link_ready      (m_link_ready)
    );

    // clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    // one input transfer; valid stays high into the next call when there is no gap
    task send_byte(input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_byte(b);
    endtask

    // hold the sender until every owed answer is back, then let the pipe empty
    task drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.owed_answers.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // register write, only issued while idle
    task write_batch_len(input logic [BATCH_LEN_WIDTH-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_batch_len(v);
    endtask

    // mostly well-formed echoes, with control bytes, broken echoes and noise
    function logic [7:0] pick_byte();
        int p;
        p = $urandom_range(0, 99);
        if (p < 62)      return sb.next_expected();
        else if (p < 72) return 8'($urandom_range(0, 255));
        else if (p < 77) return CTL_START;
        else if (p < 82) return CTL_END;
        else if (p < 86) return CTL_HELLO;
        else if (p < 89) return CTL_ACK;
        else             return 8'($urandom_range(0, 127));
    endfunction

    // result side: random stalls, check every result transfer
    initial begin
        link_result_t got;
        int           gap;
        wait (aresetn === 1'b1);
        forever begin
            gap = $urandom_range(0, idle_max);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            got.tx_valid     = m_tx_valid;
            got.tx_byte      = m_tx_byte;
            got.batch_done   = m_batch_done;
            got.rpt_received = m_report_received;
            got.rpt_sent     = m_report_sent;
            got.rpt_bad      = m_report_bad;
            got.link_ready   = m_link_ready;
            sb.check_result(got);
        end
    end

    // stimulus
    initial begin
        logic [BATCH_LEN_WIDTH-1:0] lengths[6];
        logic [7:0]                 directed[12];
        lengths  = '{14'd1, 14'd60, 14'd3, 14'd250, 14'd7, 14'h3FFF};
        directed = '{8'h05, CTL_ACK, CTL_HELLO, CTL_START, 8'h02, 8'h04,
                     8'hFF, 8'h00, 8'h84, 8'h7F, CTL_END, CTL_START};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: early data, handshake, start, mismatches, end, then a full batch
        foreach (directed[i])
            send_byte(directed[i]);
        repeat (10)
            send_byte(sb.next_expected());
        drain_results();

        // random phases over several batch lengths, from 1 up to the field's maximum
        foreach (lengths[k]) begin
            write_batch_len(lengths[k]);
            repeat (95) begin
                if ($urandom_range(0, 49) == 0)
                    drain_results();
                send_byte(pick_byte());
            end
            drain_results();
        end

        // back-to-back stretch with no stalls on either side
        idle_max = 0;
        write_batch_len(14'd9);
        send_byte(CTL_START);
        repeat (24) begin
            if ($urandom_range(0, 9) == 0)
                send_byte(8'($urandom_range(0, 127)));
            else
                send_byte(sb.next_expected());
        end
        drain_results();
        idle_max = 5;
        write_batch_len(BATCH_LEN_RESET);
        repeat (20)
            send_byte(pick_byte());
        drain_results();

        $display("run covered %0d received bytes and %0d checked answers",
                 sb.bytes_in, sb.answers_checked);
        $display("%0d batch reports seen, %0d field errors", sb.batches_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.owed_answers.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4_000_000;
        $display("timeout with %0d answers still owed", sb.owed_answers.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
